>>> src/assert_macros.svh
// Assertion shorthands used by the bound checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

// Checked only outside reset.
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`endif

>>> src/gnms_pkg.sv
`default_nettype none

package gnms_pkg;

  localparam int PIX_W       = 8;
  localparam int DIR_W       = 10;
  localparam int HEIGHT_W    = 12;
  localparam int CFG_W_W     = 11;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;
  localparam int CMD_DEPTH   = 4;
  localparam int OUT_DEPTH   = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // direction sectors
  localparam logic [1:0] SEC_HORZ = 2'd0;
  localparam logic [1:0] SEC_D45  = 2'd1;
  localparam logic [1:0] SEC_VERT = 2'd2;
  localparam logic [1:0] SEC_D135 = 2'd3;

  // source of a flushed pixel
  localparam logic [1:0] FSEL_ZERO   = 2'd0;
  localparam logic [1:0] FSEL_UPPER  = 2'd1;
  localparam logic [1:0] FSEL_MIDDLE = 2'd2;

  typedef struct packed {
    logic             is_flush;
    logic             emit;
    logic             interior;
    logic             frame_end;
    logic [1:0]       sector;
    logic [PIX_W-1:0] mag;
    logic [1:0]       fsel;
  } cmd_t;

  // one column of the line stores
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
    logic [1:0]       sector;
  } line_word_t;

endpackage

`default_nettype wire

>>> src/gradient_non_max_suppression_core.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    magnitude[7:0], direction[9:0] signed, flush
// output    out        out_valid/out_stall  pixel_out[7:0], frame_end
// config    in         cfg_write            cfg_index[0:0], cfg_data[11:0]
//
// One item per clock sustained while in_stall is low; a result leaves once the item
// that releases it has passed the command queue, the registered line-store read
// and the output queue. After reset the line store is swept to zero across all
// MAX_WIDTH addresses; geometry setup (SYNC_GEOM, SYNC_POS, SYNC_LAG) runs alongside.
// A config write stalls input for its own cycle and through those setup states.
// in_stall also rises when the command queue fills; out_stall backs up the result queue.
`default_nettype none

module gradient_non_max_suppression_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [gnms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [gnms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [gnms_pkg::PIX_W-1:0]          magnitude,
  input  wire logic signed [gnms_pkg::DIR_W-1:0]   direction,
  input  wire logic                                flush,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [gnms_pkg::PIX_W-1:0]          pixel_out,
  output      logic                                frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(gnms_pkg::cmd_t) + CW;

  logic           clr_busy;
  logic           q_full;
  logic           q_push;
  gnms_pkg::cmd_t f_cmd;
  logic [CW-1:0]  f_addr;
  logic           q_valid;
  logic           q_pop;
  gnms_pkg::cmd_t b_cmd;
  logic [CW-1:0]  b_addr;

  gnms_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .magnitude (magnitude),
    .direction (direction),
    .flush     (flush),
    .clr_busy  (clr_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (f_cmd),
    .q_addr    (f_addr)
  );

  gnms_fifo #(
    .WIDTH (QW),
    .DEPTH (gnms_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_cmd, f_addr}),
    .pop       (q_pop),
    .pop_data  ({b_cmd, b_addr}),
    .valid     (q_valid),
    .full      (q_full)
  );

  gnms_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (b_cmd),
    .q_addr    (b_addr),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

>>> src/gnms_ram.sv
`default_nettype none

module gnms_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/gnms_fifo.sv
`default_nettype none

module gnms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] pop_data,
  output      logic             valid,
  output      logic             full
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign valid    = (count != '0);
  assign full     = (count == CNTW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/gnms_front.sv
`default_nettype none

module gnms_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [gnms_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [gnms_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic [gnms_pkg::PIX_W-1:0]            magnitude,
  input  wire logic signed [gnms_pkg::DIR_W-1:0]     direction,
  input  wire logic                                  flush,
  input  wire logic                                  clr_busy,
  input  wire logic                                  q_full,
  output      logic                                  q_push,
  output      gnms_pkg::cmd_t                        q_cmd,
  output      logic [$clog2(MAX_WIDTH)-1:0]          q_addr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = gnms_pkg::HEIGHT_W;
  localparam int NW = WW + HW;

  localparam logic [1:0] ST_SYNC_GEOM = 2'd0;
  localparam logic [1:0] ST_SYNC_POS  = 2'd1;
  localparam logic [1:0] ST_SYNC_LAG  = 2'd2;
  localparam logic [1:0] ST_RUN       = 2'd3;

  logic [1:0]                   state;
  logic [gnms_pkg::CFG_W_W-1:0] frame_width;
  logic [HW-1:0]                frame_height;
  logic [WW-1:0]                w_eff;
  logic [HW-1:0]                h_eff;
  logic [NW-1:0]                n_total;
  logic [NW-1:0]                n_m1;
  logic [NW-1:0]                n_mw;
  logic [NW-1:0]                n_mw1;
  logic [NW-1:0]                w_p1;
  logic [NW-1:0]                pos;
  logic [CW-1:0]                col;
  logic [HW-1:0]                row;
  logic [NW-1:0]                oc;
  logic [NW-1:0]                lag;

  logic [31:0]   fw32;
  logic [31:0]   w_sat;
  logic [CW-1:0] col_wrap;
  logic [HW-1:0] row_wrap;
  logic [NW-1:0] oc_wrap;
  logic [NW-1:0] lag_calc;
  logic          accept;
  logic          col_last;
  logic          row_last;
  logic          oc_last;
  logic [NW-1:0] oc_inc;
  logic          emit;
  logic          honored;
  logic [WW-1:0] w_m1;
  logic [NW-1:0] mid_idx;

  function automatic logic [1:0] fold_sector(input logic signed [9:0] dir);
    logic signed [11:0] h;
    logic signed [11:0] a;
    h = $signed({{2{dir[9]}}, dir});
    if (h < -12'sd360) begin
      a = h + 12'sd720;
    end else if (h < 12'sd0) begin
      a = h + 12'sd360;
    end else if (h >= 12'sd360) begin
      a = h - 12'sd360;
    end else begin
      a = h;
    end
    if (a < 12'sd45 || a >= 12'sd315) begin
      fold_sector = gnms_pkg::SEC_HORZ;
    end else if (a < 12'sd135) begin
      fold_sector = gnms_pkg::SEC_D45;
    end else if (a < 12'sd225) begin
      fold_sector = gnms_pkg::SEC_VERT;
    end else begin
      fold_sector = gnms_pkg::SEC_D135;
    end
  endfunction

  // geometry and counter resync
  always_comb begin
    fw32 = 32'(frame_width);
    if (fw32 < 32'd3) begin
      w_sat = 32'd3;
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      w_sat = 32'(MAX_WIDTH);
    end else begin
      w_sat = fw32;
    end
    col_wrap = (WW'(col) >= w_eff) ? '0 : col;
    row_wrap = (row >= h_eff) ? '0 : row;
    oc_wrap  = (oc >= n_total) ? '0 : oc;
    lag_calc = (pos >= oc_wrap) ? pos - oc_wrap : pos + n_total - oc_wrap;
  end

  assign in_stall = (state != ST_RUN) || clr_busy || q_full || cfg_write;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_last = ((WW'(col) + WW'(1)) == w_eff);
    row_last = ((row + 1'b1) == h_eff);
    oc_last  = (oc == n_m1);
    oc_inc   = oc_last ? '0 : oc + 1'b1;
    emit     = (lag == w_p1);
    honored  = flush && (col == '0) && (row == '0) && (oc != '0);
    w_m1     = w_eff - 1'b1;
    mid_idx  = oc - n_mw;

    q_cmd.is_flush  = flush;
    q_cmd.emit      = flush || emit;
    q_cmd.interior  = (row >= HW'(2)) && (col >= CW'(2));
    q_cmd.frame_end = oc_last && (flush || emit);
    q_cmd.sector    = fold_sector(direction);
    q_cmd.mag       = magnitude;
    if (oc == n_mw1) begin
      q_cmd.fsel = gnms_pkg::FSEL_UPPER;
    end else if (oc >= n_mw) begin
      q_cmd.fsel = gnms_pkg::FSEL_MIDDLE;
    end else begin
      q_cmd.fsel = gnms_pkg::FSEL_ZERO;
    end

    if (!flush) begin
      q_addr = col;
    end else if (q_cmd.fsel == gnms_pkg::FSEL_UPPER) begin
      q_addr = CW'(w_m1);
    end else begin
      q_addr = CW'(mid_idx);
    end

    // a flush outside the frame tail is dropped
    q_push = accept && (!flush || honored);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SYNC_GEOM;
      frame_width  <= gnms_pkg::FRAME_WIDTH_RST;
      frame_height <= gnms_pkg::FRAME_HEIGHT_RST;
      col          <= '0;
      row          <= '0;
      oc           <= '0;
      lag          <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        gnms_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[gnms_pkg::CFG_W_W-1:0];
        gnms_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[HW-1:0];
        default: ;
      endcase
      state <= ST_SYNC_GEOM;
    end else begin
      case (state)
        ST_SYNC_GEOM: state <= ST_SYNC_POS;
        ST_SYNC_POS: begin
          col   <= col_wrap;
          row   <= row_wrap;
          state <= ST_SYNC_LAG;
        end
        ST_SYNC_LAG: begin
          oc    <= oc_wrap;
          lag   <= lag_calc;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (accept && flush) begin
            if (honored) begin
              oc  <= oc_inc;
              lag <= lag - 1'b1;
            end
          end else if (accept) begin
            if (col_last) begin
              col <= '0;
              row <= row_last ? '0 : row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
            if (emit) begin
              oc <= oc_inc;
            end else begin
              lag <= (lag == n_m1) ? '0 : lag + 1'b1;
            end
          end
        end
        default: state <= ST_SYNC_GEOM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SYNC_GEOM: begin
        w_eff <= WW'(w_sat);
        h_eff <= (frame_height < HW'(3)) ? HW'(3) : frame_height;
      end
      ST_SYNC_POS: begin
        n_total <= NW'(h_eff) * NW'(w_eff);
        pos     <= NW'(row_wrap) * NW'(w_eff) + NW'(col_wrap);
      end
      ST_SYNC_LAG: begin
        n_m1  <= n_total - 1'b1;
        n_mw  <= n_total - NW'(w_eff);
        n_mw1 <= n_total - NW'(w_eff) - 1'b1;
        w_p1  <= NW'(w_eff) + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/gnms_back.sv
`default_nettype none

module gnms_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire gnms_pkg::cmd_t                q_cmd,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
  output      logic                          q_pop,
  output      logic                          clr_busy,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [gnms_pkg::PIX_W-1:0]    pixel_out,
  output      logic                          frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = $bits(gnms_pkg::line_word_t);
  localparam int OW = gnms_pkg::PIX_W + 1;

  logic [CW-1:0]            clr_addr;
  logic                     s1_valid;
  gnms_pkg::cmd_t           s1_cmd;
  logic [CW-1:0]            s1_addr;
  logic                     s1_fire;
  logic                     out_full;
  logic                     byp_valid;
  gnms_pkg::line_word_t     byp_word;
  logic [LW-1:0]            ram_rdata;
  gnms_pkg::line_word_t     word;
  gnms_pkg::line_word_t     wr_word;
  logic                     ram_we;
  logic [CW-1:0]            ram_waddr;
  logic [gnms_pkg::PIX_W-1:0] win [9];
  logic [1:0]               sector_reg;
  logic [gnms_pkg::PIX_W-1:0] center;
  logic [gnms_pkg::PIX_W-1:0] na;
  logic [gnms_pkg::PIX_W-1:0] nb;
  logic [gnms_pkg::PIX_W-1:0] result;
  logic [OW-1:0]            out_data;

  assign s1_fire = s1_valid && (!s1_cmd.emit || !out_full);
  assign q_pop   = q_valid && !clr_busy && (!s1_valid || s1_fire);

  // a write to the address being read in the same cycle is forwarded
  assign word = byp_valid ? byp_word : gnms_pkg::line_word_t'(ram_rdata);

  always_comb begin
    wr_word.upper  = word.middle;
    wr_word.middle = s1_cmd.mag;
    wr_word.sector = s1_cmd.sector;
    if (clr_busy) begin
      wr_word   = '0;
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
    end else begin
      ram_we    = s1_fire && !s1_cmd.is_flush;
      ram_waddr = s1_addr;
    end
  end

  gnms_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_word),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  // window after the shift: center is old [5], new column is {upper, middle, mag}
  always_comb begin
    center = win[5];
    case (sector_reg)
      gnms_pkg::SEC_HORZ: begin
        na = win[4];
        nb = word.middle;
      end
      gnms_pkg::SEC_D45: begin
        na = win[7];
        nb = word.upper;
      end
      gnms_pkg::SEC_VERT: begin
        na = win[2];
        nb = win[8];
      end
      default: begin
        na = win[1];
        nb = s1_cmd.mag;
      end
    endcase

    if (s1_cmd.is_flush) begin
      case (s1_cmd.fsel)
        gnms_pkg::FSEL_UPPER:  result = word.upper;
        gnms_pkg::FSEL_MIDDLE: result = word.middle;
        default:               result = '0;
      endcase
    end else if (s1_cmd.interior && (center < na || center < nb)) begin
      result = '0;
    end else begin
      result = center;
    end
  end

  assign out_data = {result, s1_cmd.frame_end};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      byp_valid <= 1'b0;
      sector_reg <= '0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == CW'(MAX_WIDTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (q_pop) begin
        s1_valid  <= 1'b1;
        byp_valid <= ram_we && (ram_waddr == q_addr);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && !s1_cmd.is_flush) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3]     <= win[k*3 + 1];
          win[k*3 + 1] <= win[k*3 + 2];
        end
        win[2]     <= word.upper;
        win[5]     <= word.middle;
        win[8]     <= s1_cmd.mag;
        sector_reg <= word.sector;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd   <= q_cmd;
      s1_addr  <= q_addr;
      byp_word <= wr_word;
    end
  end

  gnms_fifo #(
    .WIDTH (OW),
    .DEPTH (gnms_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_fire && s1_cmd.emit),
    .push_data (out_data),
    .pop       (out_valid && !out_stall),
    .pop_data  ({pixel_out, frame_end}),
    .valid     (out_valid),
    .full      (out_full)
  );

endmodule

`default_nettype wire

>>> src/gnms_checker.sv
`default_nettype none
`include "assert_macros.svh"

module gnms_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       cfg_write,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [gnms_pkg::PIX_W-1:0] pixel_out,
  input wire logic                       frame_end
);

  // held result keeps its payload
  `ASSERT_RUN(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_end))

  // no item taken right after reset: line store sweep and setup follow
  `ASSERT_ALWAYS(a_reset_stalls, clk, rst |=> in_stall)

  // output queue comes out of reset empty
  `ASSERT_ALWAYS(a_reset_no_out, clk, rst |=> !out_valid)

  // geometry setup follows every config write
  `ASSERT_ALWAYS(a_cfg_stalls, clk, cfg_write |=> in_stall)

endmodule

bind gradient_non_max_suppression_core gnms_checker u_gnms_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_write (cfg_write),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pixel_out (pixel_out),
  .frame_end (frame_end)
);

`default_nettype wire

>>> test/gnms_checker.sv
module gnms_scoreboard #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [gnms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [gnms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [gnms_pkg::PIX_W-1:0]          magnitude,
  input  wire logic signed [gnms_pkg::DIR_W-1:0]   direction,
  input  wire logic                                flush,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic [gnms_pkg::PIX_W-1:0]          pixel_out,
  input  wire logic                                frame_end,
  output int                                       fail_count,
  output int                                       results_owed
);

  typedef struct packed {
    logic [gnms_pkg::PIX_W-1:0] pixel;
    logic                       frame_last;
  } nms_result_t;

  nms_result_t expected_pixels [$];

  logic [gnms_pkg::CFG_W_W-1:0]  width_reg;
  logic [gnms_pkg::HEIGHT_W-1:0] height_reg;
  logic [gnms_pkg::PIX_W-1:0]    upper_line [MAX_WIDTH];
  logic [gnms_pkg::PIX_W-1:0]    middle_line [MAX_WIDTH];
  logic [1:0]                    sector_line [MAX_WIDTH+1];
  logic [gnms_pkg::PIX_W-1:0]    win [9];
  int unsigned                   col_pos;
  int unsigned                   row_pos;
  int unsigned                   out_pos;

  function automatic logic [1:0] direction_sector(logic signed [gnms_pkg::DIR_W-1:0] dir);
    int a;
    // fold half-degrees modulo 180 degrees
    a = int'(dir) % 360;
    if (a < 0) a += 360;
    if (a < 45 || a >= 315) return gnms_pkg::SEC_HORZ;
    if (a < 135) return gnms_pkg::SEC_D45;
    if (a < 225) return gnms_pkg::SEC_VERT;
    return gnms_pkg::SEC_D135;
  endfunction

  task automatic suppress_item(input logic [gnms_pkg::PIX_W-1:0] mag,
                               input logic signed [gnms_pkg::DIR_W-1:0] dir,
                               input logic is_flush);
    int unsigned w, h, n, pos, lag, c, r, k;
    logic [gnms_pkg::PIX_W-1:0] up, mid, center, na, nb, res;
    logic [1:0] csec;
    nms_result_t item;
    w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg < 3) ? 3 : height_reg;
    n = w * h;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    if (out_pos >= n) out_pos = 0;
    c = col_pos;
    r = row_pos;
    pos = r * w + c;

    if (is_flush) begin
      // drains only once the whole frame is in and something is pending
      if (pos != 0 || out_pos == 0) return;
      if (out_pos == n - w - 1) res = upper_line[w-1];
      else if (out_pos >= n - w) res = middle_line[out_pos - (n - w)];
      else res = '0;
      item.pixel = res;
      item.frame_last = (out_pos == n - 1);
      expected_pixels.push_back(item);
      out_pos = (out_pos + 1 >= n) ? 0 : out_pos + 1;
      return;
    end

    lag = (pos + n - out_pos) % n;

    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = mag;
    for (k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = mag;

    csec = sector_line[MAX_WIDTH];
    sector_line[MAX_WIDTH] = sector_line[c];
    sector_line[c] = direction_sector(dir);

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end

    if (lag != w + 1) return;

    center = win[4];
    res = center;
    if (r >= 2 && c >= 2) begin
      case (csec)
        gnms_pkg::SEC_HORZ: begin na = win[3]; nb = win[5]; end
        gnms_pkg::SEC_D45:  begin na = win[6]; nb = win[2]; end
        gnms_pkg::SEC_VERT: begin na = win[1]; nb = win[7]; end
        default:            begin na = win[0]; nb = win[8]; end
      endcase
      if (center < na || center < nb) res = '0;
    end
    item.pixel = res;
    item.frame_last = (out_pos == n - 1);
    expected_pixels.push_back(item);
    out_pos = (out_pos + 1 >= n) ? 0 : out_pos + 1;
  endtask

  always @(posedge clk) begin : watch
    nms_result_t want;
    if (rst) begin
      expected_pixels.delete();
      width_reg = gnms_pkg::FRAME_WIDTH_RST;
      height_reg = gnms_pkg::FRAME_HEIGHT_RST;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      foreach (sector_line[i]) sector_line[i] = gnms_pkg::SEC_HORZ;
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result with nothing expected: pixel_out=%0d frame_end=%0d",
                 pixel_out, frame_end);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, pixel_out);
            fail_count++;
          end
          if (frame_end !== want.frame_last) begin
            $error("frame_end: expected %0d, got %0d", want.frame_last, frame_end);
            fail_count++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          gnms_pkg::REG_FRAME_WIDTH:  width_reg = cfg_data[gnms_pkg::CFG_W_W-1:0];
          gnms_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data[gnms_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) suppress_item(magnitude, direction, flush);
    end
    results_owed <= expected_pixels.size();
  end

endmodule

>>> test/tb_gradient_non_max_suppression_core.sv
module tb_gradient_non_max_suppression_core;

  localparam int MAX_WIDTH   = 1024;
  localparam int SETTLE_WAIT = 16;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 300000;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_write;
  logic [gnms_pkg::CFG_INDEX_W-1:0]  cfg_index;
  logic [gnms_pkg::CFG_DATA_W-1:0]   cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [gnms_pkg::PIX_W-1:0]        magnitude;
  logic signed [gnms_pkg::DIR_W-1:0] direction;
  logic                              flush;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [gnms_pkg::PIX_W-1:0]        pixel_out;
  logic                              frame_end;

  int   fail_count;
  int   results_owed;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_start = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;

  always #10 clk = ~clk;

  gradient_non_max_suppression_core #(.MAX_WIDTH(MAX_WIDTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .magnitude (magnitude),
    .direction (direction),
    .flush     (flush),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .frame_end (frame_end)
  );

  gnms_scoreboard #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .magnitude    (magnitude),
    .direction    (direction),
    .flush        (flush),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .frame_end    (frame_end),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [gnms_pkg::PIX_W-1:0] mag,
                           input logic signed [gnms_pkg::DIR_W-1:0] dir,
                           input logic is_flush);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    magnitude <= mag;
    direction <= dir;
    flush <= is_flush;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_geometry(input int wval, input int hval);
    cfg_write <= 1'b1;
    cfg_index <= gnms_pkg::REG_FRAME_WIDTH;
    cfg_data <= wval[gnms_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= gnms_pkg::REG_FRAME_HEIGHT;
    cfg_data <= hval[gnms_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [gnms_pkg::DIR_W-1:0] random_direction();
    int d;
    if ($urandom_range(4) == 0) begin
      // just around a sector boundary
      d = 45 + 90 * $urandom_range(3) - $urandom_range(1);
      if ($urandom_range(1) == 1) d = d - 360;
    end else begin
      d = $urandom_range(720) - 360;
    end
    return d[gnms_pkg::DIR_W-1:0];
  endfunction

  function automatic logic [gnms_pkg::PIX_W-1:0] random_magnitude();
    int unsigned v;
    // narrow range now and then so neighbours tie
    if ($urandom_range(3) == 0) v = $urandom_range(3);
    else v = $urandom_range(255);
    return v[gnms_pkg::PIX_W-1:0];
  endfunction

  task automatic directed_frame();
    logic [gnms_pkg::PIX_W-1:0] mags [16];
    int dirs [16];
    int k;
    mags = '{8'd0, 8'd255, 8'd7, 8'd200, 8'd100, 8'd100, 8'd50, 8'd1,
             8'd254, 8'd255, 8'd0, 8'd128, 8'd3, 8'd255, 8'd128, 8'd64};
    dirs = '{-360, 360, -1, 44, 45, 0, 90, 134, 135, 180, 270, 224, 225, 314, 315, -45};
    write_geometry(4, 4);
    for (k = 0; k < 16; k++) begin
      send_item(mags[k], dirs[k][gnms_pkg::DIR_W-1:0], 1'b0);
      if (k == 7) send_item(8'hff, 10'sd0, 1'b1);   // mid-frame flush, ignored
    end
    // taller frame with the old one pending: first flushes hit no stored line
    settle(SETTLE_WAIT);
    write_geometry(4, 5);
    repeat (10) send_item(random_magnitude(), random_direction(), 1'b1);
  endtask

  // pressure: 1 = pause until drained halfway, 2 = long receiver hold halfway
  task automatic run_phase(input int wval, input int hval, input int pixels, input bit drain,
                           input int pressure);
    int w, h, frame_px, fed;
    settle(SETTLE_WAIT);
    write_geometry(wval, hval);
    w = (wval < 3) ? 3 : ((wval > MAX_WIDTH) ? MAX_WIDTH : wval);
    h = (hval < 3) ? 3 : hval;
    frame_px = w * h;
    fed = 0;
    while (fed < pixels || (drain && fed % frame_px != 0)) begin
      if ($urandom_range(99) < 4) send_item(random_magnitude(), random_direction(), 1'b1);
      send_item(random_magnitude(), random_direction(), 1'b0);
      fed++;
      if (fed == pixels / 2) begin
        if (pressure == 1) begin
          settle(0);
        end else if (pressure == 2) begin
          in_valid <= 1'b0;
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
        end
      end
    end
    if (drain) repeat (w + 2) send_item(random_magnitude(), random_direction(), 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = gnms_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    magnitude = '0;
    direction = '0;
    flush = 1'b0;
    send_idle_pct = 14;
    recv_idle_pct = 64;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // line store clear after reset
    settle(MAX_WIDTH + SETTLE_WAIT);

    directed_frame();
    run_phase(3, 3, 90, 1'b1, 0);
    run_phase(0, 0, 60, 1'b1, 0);
    run_phase($urandom_range(16, 3), $urandom_range(10, 3), 70, 1'b1, 1);

    send_idle_pct = 64;
    recv_idle_pct <= 14;
    run_phase($urandom_range(16, 3), $urandom_range(10, 3), 70, 1'b1, 0);
    run_phase(16, 3, 70, 1'b1, 2);
    run_phase($urandom_range(16, 3), $urandom_range(10, 3), 70, 1'b1, 0);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_phase(2047, 3, 1030, 1'b0, 0);
    run_phase(7, 4095, 100, 1'b0, 0);

    settle(2 * SETTLE_WAIT);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/gnms_pkg.sv
src/gnms_ram.sv
src/gnms_fifo.sv
src/gnms_front.sv
src/gnms_back.sv
src/gradient_non_max_suppression_core.sv
src/gnms_checker.sv
test/gnms_checker.sv
test/tb_gradient_non_max_suppression_core.sv
